// ----- rtl/wsfp_pkg.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame parser package
// Shared types and constants of the frame parser: parse phases, result kinds
// and the record that travels from the parser through the queue.
// ----------------------------------------------------------------------------
package wsfp_pkg;

   typedef enum logic [2:0] {
      PH_FIRST   = 3'd0,
      PH_SECOND  = 3'd1,
      PH_EXT16   = 3'd2,
      PH_EXT64   = 3'd3,
      PH_KEY     = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_DONE    = 3'd6
   } phase_type;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic        fin;
      logic [3:0]  opcode;
      logic        masked;
      logic [63:0] payload_length;
      logic [7:0]  raw_byte;
      logic [7:0]  key_byte;
      logic        last;
   } entry_type;

endpackage

// ----- rtl/wsfp_front.sv -----
// ----------------------------------------------------------------------------
// Frame parser front end
// Accepts raw bytes, tracks the header and payload phases of the frame and
// pushes one classified record per byte that produces a result.
// ----------------------------------------------------------------------------
module wsfp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_in_byte,
   input  logic                req_end_of_buffer,
   input  logic                push_ready,
   output logic                push_valid,
   output wsfp_pkg::entry_type push_data
);

   wsfp_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [63:0] length_ff, length_in;
   logic [31:0] key_ff, key_in;
   logic [63:0] remaining_ff, remaining_in;
   logic [1:0]  keypos_ff, keypos_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;

   logic        accept;
   logic [6:0]  len7;
   logic        short_len;
   logic [3:0]  count_inc;
   logic [63:0] len_shift;
   logic        ext_done;
   logic        key_done;
   logic        hdr_emit;
   logic        pay_emit;
   logic        complete;
   wsfp_pkg::entry_type entry;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;
   assign len7      = req_in_byte[6:0];
   assign short_len = (len7 != wsfp_pkg::LEN_EXT16) && (len7 != wsfp_pkg::LEN_EXT64);
   assign count_inc = count_ff + 4'd1;
   assign len_shift = {length_ff[55:0], req_in_byte};
   assign ext_done  = ((phase_ff == wsfp_pkg::PH_EXT16) && (count_inc == wsfp_pkg::EXT16_BYTES))
                   || ((phase_ff == wsfp_pkg::PH_EXT64) && (count_inc == wsfp_pkg::EXT64_BYTES));
   assign key_done  = (phase_ff == wsfp_pkg::PH_KEY) && (count_inc == wsfp_pkg::KEY_BYTES);

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (req_end_of_buffer) begin
            phase_in = wsfp_pkg::PH_FIRST;
         end else begin
            unique case (phase_ff)
               wsfp_pkg::PH_FIRST: begin
                  phase_in = wsfp_pkg::PH_SECOND;
               end
               wsfp_pkg::PH_SECOND: begin
                  if (len7 == wsfp_pkg::LEN_EXT16) begin
                     phase_in = wsfp_pkg::PH_EXT16;
                  end else if (len7 == wsfp_pkg::LEN_EXT64) begin
                     phase_in = wsfp_pkg::PH_EXT64;
                  end else if (req_in_byte[7]) begin
                     phase_in = wsfp_pkg::PH_KEY;
                  end else if (len7 == 7'd0) begin
                     phase_in = wsfp_pkg::PH_DONE;
                  end else begin
                     phase_in = wsfp_pkg::PH_PAYLOAD;
                  end
               end
               wsfp_pkg::PH_EXT16, wsfp_pkg::PH_EXT64: begin
                  if (ext_done) begin
                     if (masked_ff) begin
                        phase_in = wsfp_pkg::PH_KEY;
                     end else if (len_shift == 64'd0) begin
                        phase_in = wsfp_pkg::PH_DONE;
                     end else begin
                        phase_in = wsfp_pkg::PH_PAYLOAD;
                     end
                  end
               end
               wsfp_pkg::PH_KEY: begin
                  if (key_done) begin
                     phase_in = (length_ff == 64'd0) ? wsfp_pkg::PH_DONE
                                                     : wsfp_pkg::PH_PAYLOAD;
                  end
               end
               wsfp_pkg::PH_PAYLOAD: begin
                  if (remaining_ff == 64'd1) begin
                     phase_in = wsfp_pkg::PH_DONE;
                  end
               end
               wsfp_pkg::PH_DONE: begin
                  phase_in = wsfp_pkg::PH_DONE;
               end
               default: begin
                  phase_in = wsfp_pkg::PH_FIRST;
               end
            endcase
         end
      end
   end

   always_comb begin
      entry.kind           = wsfp_pkg::KIND_HEADER;
      entry.fin            = fin_ff;
      entry.opcode         = opcode_ff;
      entry.masked         = masked_ff;
      entry.payload_length = length_ff;
      entry.raw_byte       = 8'd0;
      entry.key_byte       = 8'd0;
      entry.last           = 1'b0;
      hdr_emit             = 1'b0;
      pay_emit             = 1'b0;
      complete             = 1'b0;
      unique case (phase_ff)
         wsfp_pkg::PH_SECOND: begin
            if (short_len && !req_in_byte[7]) begin
               hdr_emit             = 1'b1;
               entry.masked         = 1'b0;
               entry.payload_length = 64'(len7);
               entry.last           = (len7 == 7'd0);
            end
         end
         wsfp_pkg::PH_EXT16, wsfp_pkg::PH_EXT64: begin
            if (ext_done && !masked_ff) begin
               hdr_emit             = 1'b1;
               entry.payload_length = len_shift;
               entry.last           = (len_shift == 64'd0);
            end
         end
         wsfp_pkg::PH_KEY: begin
            if (key_done) begin
               hdr_emit   = 1'b1;
               entry.last = (length_ff == 64'd0);
            end
         end
         wsfp_pkg::PH_PAYLOAD: begin
            pay_emit       = 1'b1;
            entry.kind     = wsfp_pkg::KIND_PAYLOAD;
            entry.raw_byte = req_in_byte;
            entry.key_byte = key_ff[{~keypos_ff, 3'b000} +: 8];
            entry.last     = (remaining_ff == 64'd1);
         end
         wsfp_pkg::PH_DONE: begin
            complete = 1'b1;
         end
         default: begin
            complete = 1'b0;
         end
      endcase
      if ((hdr_emit || pay_emit) && entry.last) begin
         complete = 1'b1;
      end
      push_data  = entry;
      push_valid = accept && (hdr_emit || pay_emit);
      if (req_end_of_buffer && !complete) begin
         push_data.kind           = wsfp_pkg::KIND_ERROR;
         push_data.fin            = 1'b0;
         push_data.opcode         = 4'd0;
         push_data.masked         = 1'b0;
         push_data.payload_length = 64'd0;
         push_data.raw_byte       = 8'd0;
         push_data.key_byte       = 8'd0;
         push_data.last           = 1'b1;
         push_valid               = accept;
      end
   end

   always_comb begin
      count_in     = count_ff;
      length_in    = length_ff;
      key_in       = key_ff;
      remaining_in = remaining_ff;
      keypos_in    = keypos_ff;
      fin_in       = fin_ff;
      opcode_in    = opcode_ff;
      masked_in    = masked_ff;
      case (phase_ff)
         wsfp_pkg::PH_FIRST: begin
            fin_in    = req_in_byte[7];
            opcode_in = req_in_byte[3:0];
         end
         wsfp_pkg::PH_SECOND: begin
            masked_in    = req_in_byte[7];
            count_in     = 4'd0;
            length_in    = short_len ? 64'(len7) : 64'd0;
            key_in       = 32'd0;
            remaining_in = 64'(len7);
            keypos_in    = 2'd0;
         end
         wsfp_pkg::PH_EXT16, wsfp_pkg::PH_EXT64: begin
            length_in = len_shift;
            count_in  = ext_done ? 4'd0 : count_inc;
            if (ext_done) begin
               key_in       = 32'd0;
               remaining_in = len_shift;
               keypos_in    = 2'd0;
            end
         end
         wsfp_pkg::PH_KEY: begin
            key_in   = {key_ff[23:0], req_in_byte};
            count_in = count_inc;
            if (key_done) begin
               remaining_in = length_ff;
               keypos_in    = 2'd0;
            end
         end
         wsfp_pkg::PH_PAYLOAD: begin
            keypos_in    = keypos_ff + 2'd1;
            remaining_in = remaining_ff - 64'd1;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wsfp_pkg::PH_FIRST;
         count_ff <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         if (accept) begin
            count_ff <= req_end_of_buffer ? 4'd0 : count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         length_ff    <= length_in;
         key_ff       <= key_in;
         remaining_ff <= remaining_in;
         keypos_ff    <= keypos_in;
         fin_ff       <= fin_in;
         opcode_ff    <= opcode_in;
         masked_ff    <= masked_in;
      end
   end

endmodule

// ----- rtl/wsfp_queue.sv -----
// ----------------------------------------------------------------------------
// Frame parser record queue
// Small first-in first-out buffer that decouples the parser from the output
// stage so that each side can stall on its own.
// ----------------------------------------------------------------------------
module wsfp_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  wsfp_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output wsfp_pkg::entry_type pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   wsfp_pkg::entry_type entries_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push;
   logic          pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/wsfp_back.sv -----
// ----------------------------------------------------------------------------
// Frame parser output stage
// Takes records from the queue, removes the mask from payload bytes and holds
// each result in the output register until its transfer.
// ----------------------------------------------------------------------------
module wsfp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  wsfp_pkg::entry_type pop_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic                rsp_fin,
   output logic [3:0]          rsp_opcode,
   output logic                rsp_masked,
   output logic [63:0]         rsp_payload_length,
   output logic [7:0]          rsp_data_byte,
   output logic                rsp_last
);

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff;
   logic        fin_ff;
   logic [3:0]  opcode_ff;
   logic        masked_ff;
   logic [63:0] length_ff;
   logic [7:0]  data_ff, data_in;
   logic        last_ff;
   logic        take;

   assign pop_ready = !valid_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;
   assign valid_in  = take || (valid_ff && !rsp_ready);
   assign data_in   = pop_data.raw_byte ^ pop_data.key_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff   <= pop_data.kind;
         fin_ff    <= pop_data.fin;
         opcode_ff <= pop_data.opcode;
         masked_ff <= pop_data.masked;
         length_ff <= pop_data.payload_length;
         data_ff   <= data_in;
         last_ff   <= pop_data.last;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_fin            = fin_ff;
   assign rsp_opcode         = opcode_ff;
   assign rsp_masked         = masked_ff;
   assign rsp_payload_length = length_ff;
   assign rsp_data_byte      = data_ff;
   assign rsp_last           = last_ff;

endmodule

// ----- rtl/websocket_frame_parser.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Parses one frame per received buffer, a byte per transfer, and returns a
// header result, the unmasked payload bytes, or an incomplete-frame error.
// ----------------------------------------------------------------------------
// Channel  Dir  Ports
// req      in   req_valid, req_ready, req_in_byte, req_end_of_buffer
// rsp      out  rsp_valid, rsp_ready, rsp_kind, rsp_fin, rsp_opcode, rsp_masked,
//               rsp_payload_length, rsp_data_byte, rsp_last
//
// One byte is accepted every cycle while the queue has room; the parser decides
// its result in the cycle of the transfer and registers it in the queue.
// req_ready falls only while the QUEUE_DEPTH-entry queue is full, which
// happens when rsp_ready is held low. Reset returns the parser to the first
// header byte at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module websocket_frame_parser #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic        rsp_fin,
   output logic [3:0]  rsp_opcode,
   output logic        rsp_masked,
   output logic [63:0] rsp_payload_length,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last
);

   logic                push_valid;
   logic                push_ready;
   wsfp_pkg::entry_type push_data;
   logic                pop_valid;
   logic                pop_ready;
   wsfp_pkg::entry_type pop_data;

   wsfp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .push_ready        (push_ready),
      .push_valid        (push_valid),
      .push_data         (push_data)
   );

   wsfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   wsfp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_data           (pop_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_fin            (rsp_fin),
      .rsp_opcode         (rsp_opcode),
      .rsp_masked         (rsp_masked),
      .rsp_payload_length (rsp_payload_length),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last           (rsp_last)
   );

`ifndef SYNTHESIS
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == wsfp_pkg::KIND_ERROR)
      |-> rsp_last && (rsp_payload_length == 64'd0) && (rsp_data_byte == 8'd0))
      else $error("incomplete-frame result carries stray fields");

   a_header_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == wsfp_pkg::KIND_HEADER)
      |-> (rsp_last == (rsp_payload_length == 64'd0)))
      else $error("header result last flag disagrees with its length");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == wsfp_pkg::KIND_HEADER)
                 || (rsp_kind == wsfp_pkg::KIND_PAYLOAD)
                 || (rsp_kind == wsfp_pkg::KIND_ERROR))
      else $error("result kind has no meaning");
`endif

endmodule

// ----- sim/websocket_frame_parser_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame parser checker
// Watches both channels of the frame parser. It predicts the result of every
// byte transfer with its own model of the header and payload parse, and
// compares every result transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module websocket_frame_parser_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_buffer,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_kind,
   input  logic        rsp_fin,
   input  logic [3:0]  rsp_opcode,
   input  logic        rsp_masked,
   input  logic [63:0] rsp_payload_length,
   input  logic [7:0]  rsp_data_byte,
   input  logic        rsp_last,
   output int          mismatch_count,
   output int          outstanding
);

   typedef struct packed {
      logic [1:0]  kind;
      logic        fin;
      logic [3:0]  opcode;
      logic        masked;
      logic [63:0] payload_length;
      logic [7:0]  data_byte;
      logic        last;
   } parse_result_type;

   parse_result_type expected_results[$];

   wsfp_pkg::phase_type phase;
   logic [3:0]  header_count;
   logic [63:0] length_value;
   logic [31:0] mask_key;
   logic [63:0] bytes_left;
   logic [1:0]  key_index;
   logic        frame_fin;
   logic [3:0]  frame_opcode;
   logic        frame_masked;

   task automatic clear_parser();
      phase        = wsfp_pkg::PH_FIRST;
      header_count = '0;
      length_value = '0;
      mask_key     = '0;
      bytes_left   = '0;
      key_index    = '0;
      frame_fin    = 1'b0;
      frame_opcode = '0;
      frame_masked = 1'b0;
   endtask

   function automatic parse_result_type frame_result(input logic [1:0] kind,
                                                     input logic [7:0] data,
                                                     input logic last);
      parse_result_type r;
      r.kind           = kind;
      r.fin            = frame_fin;
      r.opcode         = frame_opcode;
      r.masked         = frame_masked;
      r.payload_length = length_value;
      r.data_byte      = data;
      r.last           = last;
      return r;
   endfunction

   task automatic finish_header(output logic has_result, output logic frame_complete,
                                output parse_result_type r);
      bytes_left     = length_value;
      key_index      = '0;
      frame_complete = (length_value == 64'd0);
      r              = frame_result(wsfp_pkg::KIND_HEADER, 8'd0, frame_complete);
      has_result     = 1'b1;
      phase          = frame_complete ? wsfp_pkg::PH_DONE : wsfp_pkg::PH_PAYLOAD;
   endtask

   task automatic finish_length(output logic has_result, output logic frame_complete,
                                output parse_result_type r);
      mask_key = '0;
      if (frame_masked) begin
         phase          = wsfp_pkg::PH_KEY;
         header_count   = '0;
         has_result     = 1'b0;
         frame_complete = 1'b0;
         r              = '0;
      end else begin
         finish_header(has_result, frame_complete, r);
      end
   endtask

   task automatic parse_byte(input logic [7:0] value, input logic eob);
      logic             has_result;
      logic             frame_complete;
      logic [7:0]       key_byte;
      parse_result_type r;
      has_result     = 1'b0;
      frame_complete = 1'b0;
      r              = '0;
      case (phase)
         wsfp_pkg::PH_FIRST: begin
            frame_fin    = value[7];
            frame_opcode = value[3:0];
            frame_masked = 1'b0;
            phase        = wsfp_pkg::PH_SECOND;
         end
         wsfp_pkg::PH_SECOND: begin
            frame_masked = value[7];
            length_value = '0;
            header_count = '0;
            if (value[6:0] == wsfp_pkg::LEN_EXT16) begin
               phase = wsfp_pkg::PH_EXT16;
            end else if (value[6:0] == wsfp_pkg::LEN_EXT64) begin
               phase = wsfp_pkg::PH_EXT64;
            end else begin
               length_value = {57'd0, value[6:0]};
               finish_length(has_result, frame_complete, r);
            end
         end
         wsfp_pkg::PH_EXT16, wsfp_pkg::PH_EXT64: begin
            length_value = {length_value[55:0], value};
            header_count = header_count + 4'd1;
            if (header_count == ((phase == wsfp_pkg::PH_EXT16) ? wsfp_pkg::EXT16_BYTES
                                                               : wsfp_pkg::EXT64_BYTES)) begin
               finish_length(has_result, frame_complete, r);
            end
         end
         wsfp_pkg::PH_KEY: begin
            mask_key     = {mask_key[23:0], value};
            header_count = header_count + 4'd1;
            if (header_count == wsfp_pkg::KEY_BYTES) begin
               finish_header(has_result, frame_complete, r);
            end
         end
         wsfp_pkg::PH_PAYLOAD: begin
            key_byte       = mask_key[(3 - key_index) * 8 +: 8];
            key_index      = key_index + 2'd1;
            bytes_left     = bytes_left - 64'd1;
            frame_complete = (bytes_left == 64'd0);
            r              = frame_result(wsfp_pkg::KIND_PAYLOAD, value ^ key_byte,
                                          frame_complete);
            has_result     = 1'b1;
            if (frame_complete) begin
               phase = wsfp_pkg::PH_DONE;
            end
         end
         default: begin
            frame_complete = 1'b1;
         end
      endcase
      // A buffer that ends before its frame is complete yields only the error.
      if (eob) begin
         if (!frame_complete) begin
            r          = '0;
            r.kind     = wsfp_pkg::KIND_ERROR;
            r.last     = 1'b1;
            has_result = 1'b1;
         end
         clear_parser();
      end
      if (has_result) begin
         expected_results.push_back(r);
      end
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      parse_result_type want;
      if (reset) begin
         expected_results.delete();
         clear_parser();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result transfer, kind %0h data %0h last %0b",
                        $time, rsp_kind, rsp_data_byte, rsp_last);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("kind", 64'(want.kind), 64'(rsp_kind));
               check_field("fin", 64'(want.fin), 64'(rsp_fin));
               check_field("opcode", 64'(want.opcode), 64'(rsp_opcode));
               check_field("masked", 64'(want.masked), 64'(rsp_masked));
               check_field("payload_length", want.payload_length, rsp_payload_length);
               check_field("data_byte", 64'(want.data_byte), 64'(rsp_data_byte));
               check_field("last", 64'(want.last), 64'(rsp_last));
            end
         end
         if (req_valid && req_ready) begin
            parse_byte(req_in_byte, req_end_of_buffer);
         end
      end
      outstanding = expected_results.size();
   end

endmodule

// ----- sim/websocket_frame_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame parser testbench
// Feeds the parser with directed buffers and then with random buffers, mostly
// well-formed frames with random content, some cut short, some noise. Both
// sides pause at random, and the receiver once holds off long enough to stall
// the input. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module websocket_frame_parser_tb;

   localparam int ITEM_TARGET  = 1300;
   localparam int STEADY_FROM  = 1150;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_BODY     = 400;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        req_end_of_buffer;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_kind;
   logic        rsp_fin;
   logic [3:0]  rsp_opcode;
   logic        rsp_masked;
   logic [63:0] rsp_payload_length;
   logic [7:0]  rsp_data_byte;
   logic        rsp_last;

   int          mismatch_count;
   int          outstanding;
   int          idle_cycles = 0;
   int          sent_items  = 0;
   int          gap_odds    = 0;
   bit          steady      = 1'b0;
   bit          long_hold   = 1'b0;
   logic [7:0]  frame_bytes[$];

   websocket_frame_parser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .req_end_of_buffer  (req_end_of_buffer),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_fin            (rsp_fin),
      .rsp_opcode         (rsp_opcode),
      .rsp_masked         (rsp_masked),
      .rsp_payload_length (rsp_payload_length),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last           (rsp_last)
   );

   websocket_frame_parser_checker frame_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .req_end_of_buffer  (req_end_of_buffer),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_fin            (rsp_fin),
      .rsp_opcode         (rsp_opcode),
      .rsp_masked         (rsp_masked),
      .rsp_payload_length (rsp_payload_length),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last           (rsp_last),
      .mismatch_count     (mismatch_count),
      .outstanding        (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("websocket_frame_parser_tb: errors");
         $finish;
      end
   end

   function automatic logic [7:0] random_byte();
      return 8'($urandom);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input logic [7:0] value, input logic eob);
      steady = (sent_items >= STEADY_FROM);
      if (!steady && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= value;
      req_end_of_buffer <= eob;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic send_buffer();
      gap_odds = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(3, 12);
      foreach (frame_bytes[i]) begin
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
      frame_bytes.delete();
   endtask

   task automatic build_random_buffer();
      logic [63:0] frame_length;
      logic [6:0]  short_length;
      logic        masked;
      int          ext_bytes;
      int          body_count;
      int          cut;
      int          pick;
      bit          oversize;
      if ($urandom_range(0, 9) < 8) begin
         masked = 1'($urandom_range(0, 1));
         pick   = $urandom_range(0, 9);
         if (pick < 6) begin
            frame_length = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 125))
                                                       : 64'($urandom_range(0, 12));
            short_length = frame_length[6:0];
            ext_bytes    = 0;
         end else if (pick < 8) begin
            frame_length = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(0, 65535))
                                                       : 64'($urandom_range(0, 40));
            short_length = wsfp_pkg::LEN_EXT16;
            ext_bytes    = 2;
         end else begin
            frame_length = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                       : 64'($urandom_range(0, 40));
            short_length = wsfp_pkg::LEN_EXT64;
            ext_bytes    = 8;
         end
         frame_bytes.push_back(random_byte());
         frame_bytes.push_back({masked, short_length});
         for (int i = ext_bytes - 1; i >= 0; i--) begin
            frame_bytes.push_back(frame_length[8 * i +: 8]);
         end
         if (masked) begin
            repeat (4) frame_bytes.push_back(random_byte());
         end
         // Very long frames are always cut short after a few payload bytes.
         oversize   = (frame_length > MAX_BODY);
         body_count = oversize ? int'($urandom_range(0, 6)) : int'(frame_length);
         repeat (body_count) frame_bytes.push_back(random_byte());
         if (!oversize && $urandom_range(0, 3) == 0) begin
            cut = int'($urandom_range(1, frame_bytes.size() - 1));
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
         end else if (!oversize) begin
            repeat ($urandom_range(0, 3)) frame_bytes.push_back(random_byte());
         end
      end else begin
         repeat ($urandom_range(1, 6)) frame_bytes.push_back(random_byte());
      end
   endtask

   initial begin
      int ready_odds;
      int window;
      rsp_ready  = 1'b0;
      ready_odds = 0;
      window     = 0;
      forever begin
         @(negedge clock);
         if (window == 0) begin
            window     = 64;
            ready_odds = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(3, 10);
         end
         window--;
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_ready <= 1'b1;
            long_hold = 1'b0;
         end else if (!steady && ready_odds != 0 && $urandom_range(1, ready_odds) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_in_byte       = 8'd0;
      req_end_of_buffer = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // A buffer that ends on the first header byte.
      frame_bytes = {8'hFF};
      send_buffer();
      // Final fragment, opcode 15, empty payload: the header closes the frame.
      frame_bytes = {8'h8F, 8'h00};
      send_buffer();
      // Masked frame of four bytes, so every key byte is used once.
      frame_bytes = {8'h82, 8'h84, 8'hA5, 8'h5A, 8'hFF, 8'h00,
                     8'h00, 8'hFF, 8'h3C, 8'hC3};
      send_buffer();
      // Extended length with the top bit set, cut short after the length.
      frame_bytes = {8'h80, 8'h7F, 8'h80, 8'h00, 8'h00, 8'h00,
                     8'h00, 8'h00, 8'h00, 8'h01};
      send_buffer();
      // Sixteen-bit length below 126, followed by bytes after the frame.
      frame_bytes = {8'h01, 8'h7E, 8'h00, 8'h01, 8'h41, 8'h55};
      send_buffer();

      long_hold = 1'b1;
      while (sent_items < ITEM_TARGET) begin
         build_random_buffer();
         send_buffer();
      end
      req_valid <= 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("websocket_frame_parser_tb: clean");
      end else begin
         $display("websocket_frame_parser_tb: errors");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/wsfp_pkg.sv
rtl/wsfp_front.sv
rtl/wsfp_queue.sv
rtl/wsfp_back.sv
rtl/websocket_frame_parser.sv
sim/websocket_frame_parser_checker.sv
sim/websocket_frame_parser_tb.sv
